// ===== hw/rtl/nnk_pkg.sv =====
// ----------------------------------------------------------------------------
// nnk_pkg - shared definitions for the top-k nearest neighbor core
// Function codes, field widths, parameter defaults and the control structs
// that travel between the pipeline stages.
// ----------------------------------------------------------------------------
package nnk_pkg;

   localparam int TOP_K_DEF        = 5;
   localparam int FEATURE_BITS_DEF = 16;
   localparam int NUM_FEAT         = 4;
   localparam int ID_W             = 16;
   localparam int OUT_DIST_W       = 34;
   localparam int RANK_W           = 3;
   localparam int FUNC_W           = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_QUERY  = 2'd0,
      FUNC_REF    = 2'd1,
      FUNC_FINISH = 2'd2
   } func_type;

   // Control that rides along with an item through the pipeline.
   typedef struct packed {
      logic             valid;
      func_type         func;
      logic [ID_W-1:0]  id;
   } stage_ctl_type;

   // Status from the list stage to the emit sequencer.
   typedef struct packed {
      logic fin_fire;
      logic empty;
      logic rd_last;
   } list_stat_type;

endpackage

// ===== hw/rtl/nnk_lane.sv =====
// ----------------------------------------------------------------------------
// nnk_lane - one feature lane
// Subtracts the query feature from the beat's feature and registers the
// square of the difference.
// ----------------------------------------------------------------------------
module nnk_lane #(
   parameter int FEATURE_BITS = nnk_pkg::FEATURE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [FEATURE_BITS-1:0]   query,
   input  logic [FEATURE_BITS-1:0]   feat,
   output logic [2*FEATURE_BITS-1:0] sq_ff
);

   localparam int FB = FEATURE_BITS;

   logic [FB:0]     diff;
   logic [FB-1:0]   mag;
   logic [2*FB-1:0] sq_in;

   // The difference of two signed values needs one extra bit; its magnitude
   // always fits in FB unsigned bits.
   assign diff  = {feat[FB-1], feat} - {query[FB-1], query};
   assign mag   = diff[FB] ? FB'(-diff) : diff[FB-1:0];
   assign sq_in = (2*FB)'(mag) * (2*FB)'(mag);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
      end
   end

endmodule

// ===== hw/rtl/nnk_list.sv =====
// ----------------------------------------------------------------------------
// nnk_list - merge stage and sorted result list
// Adds the lane squares into the distance, then inserts it into the sorted
// list by comparing against every held entry at once.
// ----------------------------------------------------------------------------
module nnk_list #(
   parameter int TOP_K        = nnk_pkg::TOP_K_DEF,
   parameter int FEATURE_BITS = nnk_pkg::FEATURE_BITS_DEF,
   localparam int DIST_W      = 2 * FEATURE_BITS + 2,
   localparam int IDX_W       = (TOP_K > 1) ? $clog2(TOP_K) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  nnk_pkg::stage_ctl_type        s1_ctl,
   input  logic [2*FEATURE_BITS-1:0]     sq [nnk_pkg::NUM_FEAT],
   input  logic [IDX_W-1:0]              rd_idx,
   output nnk_pkg::list_stat_type        stat,
   output logic [DIST_W-1:0]             rd_dist,
   output logic [nnk_pkg::ID_W-1:0]      rd_id
);

   localparam int CNT_W = $clog2(TOP_K + 1);

   nnk_pkg::stage_ctl_type   s2_ctl_ff;
   logic [DIST_W-1:0]        s2_dist_ff;
   logic [DIST_W-1:0]        s2_dist_in;

   logic [DIST_W-1:0]        ent_dist_ff [TOP_K];
   logic [DIST_W-1:0]        ent_dist_in [TOP_K];
   logic [nnk_pkg::ID_W-1:0] ent_id_ff   [TOP_K];
   logic [nnk_pkg::ID_W-1:0] ent_id_in   [TOP_K];
   logic [CNT_W-1:0]         cnt_ff;
   logic [CNT_W-1:0]         cnt_in;

   logic [TOP_K-1:0] lt;
   logic [TOP_K-1:0] eq;
   logic             proc;
   logic             drop;
   logic             do_ins;

   always_comb begin
      s2_dist_in = '0;
      for (int f = 0; f < nnk_pkg::NUM_FEAT; f++) begin
         s2_dist_in = s2_dist_in + DIST_W'(sq[f]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (adv) begin
         s2_ctl_ff <= s1_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_dist_ff <= s2_dist_in;
      end
   end

   // The list is sorted, so the less-than flags form a thermometer code and
   // the insert point is where it ends.
   always_comb begin
      for (int i = 0; i < TOP_K; i++) begin
         lt[i] = (CNT_W'(i) < cnt_ff) && (ent_dist_ff[i] < s2_dist_ff);
         eq[i] = (CNT_W'(i) < cnt_ff) && (ent_dist_ff[i] == s2_dist_ff);
      end
   end

   assign proc   = adv && s2_ctl_ff.valid;
   assign drop   = (|eq) || lt[TOP_K-1];
   assign do_ins = proc && (s2_ctl_ff.func == nnk_pkg::FUNC_REF) && !drop;

   for (genvar g = 0; g < TOP_K; g++) begin : g_ent
      if (g == 0) begin : g_head
         always_comb begin
            ent_dist_in[g] = ent_dist_ff[g];
            ent_id_in[g]   = ent_id_ff[g];
            if (do_ins && !lt[g]) begin
               ent_dist_in[g] = s2_dist_ff;
               ent_id_in[g]   = s2_ctl_ff.id;
            end
         end
      end else begin : g_body
         always_comb begin
            ent_dist_in[g] = ent_dist_ff[g];
            ent_id_in[g]   = ent_id_ff[g];
            if (do_ins && !lt[g] && lt[g-1]) begin
               ent_dist_in[g] = s2_dist_ff;
               ent_id_in[g]   = s2_ctl_ff.id;
            end else if (do_ins && !lt[g-1]) begin
               ent_dist_in[g] = ent_dist_ff[g-1];
               ent_id_in[g]   = ent_id_ff[g-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TOP_K; i++) begin
         ent_dist_ff[i] <= ent_dist_in[i];
         ent_id_ff[i]   <= ent_id_in[i];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (proc && (s2_ctl_ff.func == nnk_pkg::FUNC_QUERY)) begin
         cnt_in = '0;
      end else if (do_ins && (cnt_ff != CNT_W'(TOP_K))) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign stat.fin_fire = proc && (s2_ctl_ff.func == nnk_pkg::FUNC_FINISH);
   assign stat.empty    = (cnt_ff == '0);
   assign stat.rd_last  = ((CNT_W'(rd_idx) + CNT_W'(1)) == cnt_ff);
   assign rd_dist       = ent_dist_ff[rd_idx];
   assign rd_id         = ent_id_ff[rd_idx];

endmodule

// ===== hw/rtl/nearest_neighbor_top_k_core.sv =====
// A finish's first result beat passes the s1 and s2 control registers and the emit
// sequencer before it enters the output register. Throughput: one query or reference
// beat per cycle through the feature lanes unless a finish is being walked out; a finish
// holds the input until the single emit sequencer that walks the list has loaded all of
// its results (at least one). Reset clears the list count, query and valids.
// ----------------------------------------------------------------------------
// nearest_neighbor_top_k_core - top-k nearest neighbor search
// Four feature lanes square the query-to-reference differences, the list
// stage sums them and keeps the TOP_K nearest in ascending order, and a
// finish walks the list out through a registered result port.
// ----------------------------------------------------------------------------
module nearest_neighbor_top_k_core #(
   parameter int TOP_K        = nnk_pkg::TOP_K_DEF,
   parameter int FEATURE_BITS = nnk_pkg::FEATURE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [nnk_pkg::FUNC_W-1:0]        req_func,
   input  logic [FEATURE_BITS-1:0]           req_feat_a,
   input  logic [FEATURE_BITS-1:0]           req_feat_b,
   input  logic [FEATURE_BITS-1:0]           req_feat_c,
   input  logic [FEATURE_BITS-1:0]           req_feat_d,
   input  logic [nnk_pkg::ID_W-1:0]          req_ref_id,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [nnk_pkg::ID_W-1:0]          rsp_out_id,
   output logic [nnk_pkg::OUT_DIST_W-1:0]    rsp_out_distance,
   output logic [nnk_pkg::RANK_W-1:0]        rsp_rank,
   output logic                              rsp_found,
   output logic                              rsp_last
);

   localparam int FB     = FEATURE_BITS;
   localparam int DIST_W = 2 * FB + 2;
   localparam int IDX_W  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
   localparam int EXT_W  = (DIST_W > nnk_pkg::OUT_DIST_W) ? DIST_W : nnk_pkg::OUT_DIST_W;
   localparam int RK_W   = (IDX_W > nnk_pkg::RANK_W) ? IDX_W : nnk_pkg::RANK_W;

   // Input side. The pipeline moves as a whole and only stops while a
   // finish is being walked out, so the list cannot change under it.
   logic                   accept;
   logic                   adv;
   logic                   func_ok;
   logic [FB-1:0]          feat   [nnk_pkg::NUM_FEAT];
   logic [FB-1:0]          query_ff [nnk_pkg::NUM_FEAT];
   logic [2*FB-1:0]        sq     [nnk_pkg::NUM_FEAT];
   nnk_pkg::stage_ctl_type s1_ctl_ff;
   nnk_pkg::stage_ctl_type s1_ctl_in;

   // Emit side.
   nnk_pkg::list_stat_type stat;
   logic [DIST_W-1:0]      rd_dist;
   logic [nnk_pkg::ID_W-1:0] rd_id;
   logic [EXT_W-1:0]       rd_dist_ext;
   logic [RK_W-1:0]        rank_ext;
   logic                   emit_ff;
   logic                   emit_in;
   logic [IDX_W-1:0]       emit_idx_ff;
   logic [IDX_W-1:0]       emit_idx_in;
   logic                   load;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [nnk_pkg::ID_W-1:0]       rsp_id_ff;
   logic [nnk_pkg::OUT_DIST_W-1:0] rsp_dist_ff;
   logic [nnk_pkg::RANK_W-1:0]     rsp_rank_ff;
   logic                   rsp_found_ff;
   logic                   rsp_last_ff;

   assign adv       = !emit_ff;
   assign req_ready = !emit_ff;
   assign accept    = req_valid && req_ready;

   assign feat[0] = req_feat_a;
   assign feat[1] = req_feat_b;
   assign feat[2] = req_feat_c;
   assign feat[3] = req_feat_d;

   // An unused function code enters as a bubble and changes nothing.
   assign func_ok = (req_func == nnk_pkg::FUNC_QUERY) ||
                    (req_func == nnk_pkg::FUNC_REF) ||
                    (req_func == nnk_pkg::FUNC_FINISH);

   always_comb begin
      s1_ctl_in.valid = accept && func_ok;
      s1_ctl_in.func  = nnk_pkg::func_type'(req_func);
      s1_ctl_in.id    = req_ref_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (adv) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   // The query takes effect at once, so a reference in the very next beat
   // is already measured against it. The list is cleared later, in order,
   // when the query beat reaches the list stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < nnk_pkg::NUM_FEAT; f++) begin
            query_ff[f] <= '0;
         end
      end else if (accept && (req_func == nnk_pkg::FUNC_QUERY)) begin
         for (int f = 0; f < nnk_pkg::NUM_FEAT; f++) begin
            query_ff[f] <= feat[f];
         end
      end
   end

   for (genvar g = 0; g < nnk_pkg::NUM_FEAT; g++) begin : g_lane
      nnk_lane #(
         .FEATURE_BITS (FEATURE_BITS)
      ) u_lane (
         .clock (clock),
         .en    (adv),
         .query (query_ff[g]),
         .feat  (feat[g]),
         .sq_ff (sq[g])
      );
   end

   nnk_list #(
      .TOP_K        (TOP_K),
      .FEATURE_BITS (FEATURE_BITS)
   ) u_list (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .s1_ctl  (s1_ctl_ff),
      .sq      (sq),
      .rd_idx  (emit_idx_ff),
      .stat    (stat),
      .rd_dist (rd_dist),
      .rd_id   (rd_id)
   );

   // Emit sequencer. A finish at the list stage starts a walk from entry
   // zero; each entry moves into the output register whenever it is empty
   // or being drained, so the input stays stalled only for the walk itself.
   // An empty list gives a single beat with found clear.
   assign load        = emit_ff && (!rsp_valid_ff || rsp_ready);
   assign rd_dist_ext = EXT_W'(rd_dist);
   assign rank_ext    = RK_W'(emit_idx_ff);

   always_comb begin
      emit_in     = emit_ff;
      emit_idx_in = emit_idx_ff;
      if (stat.fin_fire) begin
         emit_in     = 1'b1;
         emit_idx_in = '0;
      end else if (load) begin
         emit_idx_in = emit_idx_ff + IDX_W'(1);
         if (stat.empty || stat.rd_last) begin
            emit_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff      <= 1'b0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emit_ff      <= emit_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (stat.empty) begin
            rsp_id_ff    <= '0;
            rsp_dist_ff  <= '0;
            rsp_rank_ff  <= '0;
            rsp_found_ff <= 1'b0;
            rsp_last_ff  <= 1'b1;
         end else begin
            rsp_id_ff    <= rd_id;
            rsp_dist_ff  <= rd_dist_ext[nnk_pkg::OUT_DIST_W-1:0];
            rsp_rank_ff  <= rank_ext[nnk_pkg::RANK_W-1:0];
            rsp_found_ff <= 1'b1;
            rsp_last_ff  <= stat.rd_last;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_id       = rsp_id_ff;
   assign rsp_out_distance = rsp_dist_ff;
   assign rsp_rank         = rsp_rank_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   // An empty-list beat is always the only beat of its run.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> rsp_last_ff)
      else $error("empty-list result beat without last");

   // The sequencer never leaves a free output register unused during a walk.
   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      (emit_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("emit walk left the output register empty");

   // A walk ends only by loading the last beat of the run.
   a_walk_ends_last: assert property (@(posedge clock) disable iff (reset)
      $fell(emit_ff) |-> (rsp_valid_ff && rsp_last_ff))
      else $error("emit walk ended without a last beat");

   // While a walk is running the input side is held.
   a_hold_during_walk: assert property (@(posedge clock) disable iff (reset)
      (emit_ff && $past(emit_ff)) |-> $stable(s1_ctl_ff))
      else $error("pipeline moved during an emit walk");
`endif

endmodule
